FILE: sv/rist_pkg.sv
`timescale 1ns / 1ps

package rist_pkg;

    // operation codes carried on the slave tuser
    typedef logic [2:0] opcode_t;
    localparam opcode_t OP_ACQUIRE = 3'd0;
    localparam opcode_t OP_ADDREF  = 3'd1;
    localparam opcode_t OP_RELEASE = 3'd2;
    localparam opcode_t OP_FLUSH   = 3'd3;
    localparam opcode_t OP_PIN     = 3'd4;
    localparam opcode_t OP_CLEAR   = 3'd5;

    // result status codes carried on the master tuser
    typedef logic [1:0] status_t;
    localparam status_t ST_HIT  = 2'd0;
    localparam status_t ST_NEW  = 2'd1;
    localparam status_t ST_FULL = 2'd2;
    localparam status_t ST_DONE = 2'd3;

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic start;
        logic cmp_en;
        logic pin_mode;
    } scan_ctl_t;

    // what the scan has found so far
    typedef struct packed {
        logic have_hit;
        logic have_free;
    } scan_flags_t;

endpackage

FILE: sv/rist_store.sv
`timescale 1ns / 1ps

module rist_store #(
    parameter int SLOTS      = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(SLOTS)-1:0] wr_addr,
    input  logic [31:0]              wr_key,
    input  logic [31:0]              wr_dict,
    input  logic [COUNT_BITS-1:0]    wr_count,
    input  logic                     wr_perm,
    input  logic                     wr_comp,
    input  logic [$clog2(SLOTS)-1:0] rd_addr,
    output logic [31:0]              rd_key,
    output logic [31:0]              rd_dict,
    output logic [COUNT_BITS-1:0]    rd_count,
    output logic                     rd_perm,
    output logic                     rd_comp
);

    logic [31:0]           key_mem   [SLOTS];
    logic [31:0]           dict_mem  [SLOTS];
    logic [COUNT_BITS-1:0] count_mem [SLOTS];
    logic                  perm_mem  [SLOTS];
    logic                  comp_mem  [SLOTS];

    logic [31:0]           rd_key_reg;
    logic [31:0]           rd_dict_reg;
    logic [COUNT_BITS-1:0] rd_count_reg;
    logic                  rd_perm_reg;
    logic                  rd_comp_reg;

    // single write port, one whole slot record at a time
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]   <= wr_key;
            dict_mem[wr_addr]  <= wr_dict;
            count_mem[wr_addr] <= wr_count;
            perm_mem[wr_addr]  <= wr_perm;
            comp_mem[wr_addr]  <= wr_comp;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_key_reg   <= key_mem[rd_addr];
        rd_dict_reg  <= dict_mem[rd_addr];
        rd_count_reg <= count_mem[rd_addr];
        rd_perm_reg  <= perm_mem[rd_addr];
        rd_comp_reg  <= comp_mem[rd_addr];
    end

    assign rd_key   = rd_key_reg;
    assign rd_dict  = rd_dict_reg;
    assign rd_count = rd_count_reg;
    assign rd_perm  = rd_perm_reg;
    assign rd_comp  = rd_comp_reg;

endmodule

FILE: sv/rist_match.sv
`timescale 1ns / 1ps

module rist_match #(
    parameter int SLOTS      = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rist_pkg::scan_ctl_t          ctl,
    input  logic [$clog2(SLOTS)-1:0]     idx,
    input  logic [31:0]                  lookup_key,
    input  logic [31:0]                  slot_key,
    input  logic [COUNT_BITS-1:0]        slot_count,
    input  logic                         slot_perm,
    output rist_pkg::scan_flags_t        flags,
    output logic [$clog2(SLOTS)-1:0]     hit_idx,
    output logic [$clog2(SLOTS)-1:0]     free_idx
);

    import rist_pkg::*;

    localparam int IW = $clog2(SLOTS);

    logic          have_hit_reg, have_hit_next;
    logic          have_free_reg, have_free_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic          slot_free;
    logic          key_eq;
    logic          slot_match;

    // one slot compared per cycle
    always_comb
    begin
        slot_free  = !slot_perm && (slot_count == '0);
        key_eq     = (slot_key == lookup_key);
        slot_match = key_eq && (ctl.pin_mode ? slot_perm : !slot_free);
    end

    // keep the lowest hit and the lowest free slot seen
    always_comb
    begin
        have_hit_next  = have_hit_reg;
        have_free_next = have_free_reg;
        hit_idx_next   = hit_idx_reg;
        free_idx_next  = free_idx_reg;
        if (ctl.start)
        begin
            have_hit_next  = 1'b0;
            have_free_next = 1'b0;
        end
        else if (ctl.cmp_en)
        begin
            if (!have_free_reg && slot_free)
            begin
                have_free_next = 1'b1;
                free_idx_next  = idx;
            end
            if (!have_hit_reg && slot_match)
            begin
                have_hit_next = 1'b1;
                hit_idx_next  = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_hit_reg  <= 1'b0;
            have_free_reg <= 1'b0;
        end
        else
        begin
            have_hit_reg  <= have_hit_next;
            have_free_reg <= have_free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
    end

    assign flags.have_hit  = have_hit_reg;
    assign flags.have_free = have_free_reg;
    assign hit_idx         = hit_idx_reg;
    assign free_idx        = free_idx_reg;

endmodule

FILE: sv/refcounted_image_slot_table.sv
`timescale 1ns / 1ps
// channel  | direction | handshake        | payload
// s_       | in        | s_tvalid/tready  | s_tuser opcode, s_tdata key, dict, held, comp
// m_       | out       | m_tvalid/tready  | m_tuser status, m_tdata slot_index
//
// one item at a time; acquire and permanent insert scan every slot through one
// comparator on the single read port; acquire then updates up to 2 slots (read
// and write back each) before any fill; flush and clear pass over every slot, add
// reference and release update the held slot only if valid, spare opcodes only answer
// after reset a clearing pass writes all SLOTS entries before s_tready rises
// a new transaction is taken while the previous result waits on m_; the block
// then holds its finished result until m_tready frees the output register

module refcounted_image_slot_table #(
    parameter int SLOTS      = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // opcode
    input  logic [71:0] s_tdata,   // image_key, dictionary_handle, held_valid,
                                   // held_slot, is_compressed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // status
    output logic [7:0]  m_tdata    // slot_index, zero pad
);

    import rist_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLR    = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_RMW_RD = 4'd4;
    localparam logic [3:0] S_RMW_WR = 4'd5;
    localparam logic [3:0] S_FILL   = 4'd6;
    localparam logic [3:0] S_FLUSH  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    localparam logic [1:0] F_NONE = 2'd0;
    localparam logic [1:0] F_UP   = 2'd1;
    localparam logic [1:0] F_FILL = 2'd2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // input fields
    logic [31:0] in_key;
    logic [31:0] in_dict;
    logic        in_held_valid;
    logic [5:0]  in_held;
    logic        in_comp;
    logic        in_held_ok;
    opcode_t     in_op;

    assign in_op         = s_tuser;
    assign in_key        = s_tdata[31:0];
    assign in_dict       = s_tdata[63:32];
    assign in_held_valid = s_tdata[64];
    assign in_held       = s_tdata[70:65];
    assign in_comp       = s_tdata[71];
    assign in_held_ok    = in_held_valid && (32'(in_held) < 32'(SLOTS));

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pend_reg, pend_next;
    opcode_t       op_reg, op_next;
    logic [31:0]   key_reg, key_next;
    logic [31:0]   dict_reg, dict_next;
    logic          comp_reg, comp_next;
    logic          held_ok_reg, held_ok_next;
    logic [IW-1:0] held_reg, held_next;
    logic [IW-1:0] upd_slot_reg, upd_slot_next;
    logic          upd_up_reg, upd_up_next;
    logic [1:0]    follow_reg, follow_next;
    logic [IW-1:0] res_idx_reg, res_idx_next;
    status_t       res_status_reg, res_status_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [5:0]    m_idx_reg, m_idx_next;
    status_t       m_status_reg, m_status_next;

    // store ports
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [31:0]           wr_key;
    logic [31:0]           wr_dict;
    logic [COUNT_BITS-1:0] wr_count;
    logic                  wr_perm;
    logic                  wr_comp;
    logic [IW-1:0]         rd_addr;
    logic [31:0]           rd_key;
    logic [31:0]           rd_dict;
    logic [COUNT_BITS-1:0] rd_count;
    logic                  rd_perm;
    logic                  rd_comp;

    scan_ctl_t     sctl;
    scan_flags_t   sflags;
    logic [IW-1:0] hit_idx;
    logic [IW-1:0] free_idx;
    logic [IW-1:0] prev_idx;
    logic          accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign prev_idx = IW'(cnt_reg - CW'(1));

    rist_store #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_key   (wr_key),
        .wr_dict  (wr_dict),
        .wr_count (wr_count),
        .wr_perm  (wr_perm),
        .wr_comp  (wr_comp),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_dict  (rd_dict),
        .rd_count (rd_count),
        .rd_perm  (rd_perm),
        .rd_comp  (rd_comp)
    );

    rist_match #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_match (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (sctl),
        .idx        (prev_idx),
        .lookup_key (key_reg),
        .slot_key   (rd_key),
        .slot_count (rd_count),
        .slot_perm  (rd_perm),
        .flags      (sflags),
        .hit_idx    (hit_idx),
        .free_idx   (free_idx)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        dict_next       = dict_reg;
        comp_next       = comp_reg;
        held_ok_next    = held_ok_reg;
        held_next       = held_reg;
        upd_slot_next   = upd_slot_reg;
        upd_up_next     = upd_up_reg;
        follow_next     = follow_reg;
        res_idx_next    = res_idx_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_idx_next      = m_idx_reg;
        m_status_next   = m_status_reg;

        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_key   = '0;
        wr_dict  = '0;
        wr_count = '0;
        wr_perm  = 1'b0;
        wr_comp  = 1'b0;
        rd_addr  = '0;

        sctl.start    = accept;
        sctl.cmp_en   = 1'b0;
        sctl.pin_mode = (op_reg == OP_PIN);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pend_next       = 1'b1;
                    op_next         = in_op;
                    key_next        = in_key;
                    dict_next       = in_dict;
                    comp_next       = in_comp;
                    held_ok_next    = in_held_ok;
                    held_next       = IW'(in_held);
                    res_idx_next    = '0;
                    res_status_next = ST_DONE;
                    cnt_next        = '0;
                    upd_slot_next   = IW'(in_held);
                    upd_up_next     = (in_op == OP_ADDREF);
                    follow_next     = F_NONE;
                    case (in_op)
                        OP_ACQUIRE, OP_PIN:
                            state_next = S_SCAN;
                        OP_ADDREF, OP_RELEASE:
                            state_next = in_held_ok ? S_RMW_RD : S_DONE;
                        OP_FLUSH:
                            state_next = S_FLUSH;
                        OP_CLEAR:
                            state_next = S_CLR;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end

            // clearing pass, one slot per cycle
            S_CLR:
            begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg[IW-1:0];
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(SLOTS - 1))
                begin
                    state_next = pend_reg ? S_DONE : S_IDLE;
                end
            end

            // read slot cnt, compare slot cnt-1
            S_SCAN:
            begin
                rd_addr     = cnt_reg[IW-1:0];
                sctl.cmp_en = (cnt_reg != '0);
                cnt_next    = cnt_reg + CW'(1);
                if (cnt_reg == CW'(SLOTS))
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (sflags.have_hit)
                begin
                    res_idx_next    = hit_idx;
                    res_status_next = ST_HIT;
                    if (op_reg == OP_ACQUIRE && !(held_ok_reg && held_reg == hit_idx))
                    begin
                        state_next = S_RMW_RD;
                        if (held_ok_reg)
                        begin
                            upd_slot_next = held_reg;
                            upd_up_next   = 1'b0;
                            follow_next   = F_UP;
                        end
                        else
                        begin
                            upd_slot_next = hit_idx;
                            upd_up_next   = 1'b1;
                            follow_next   = F_NONE;
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (!sflags.have_free)
                begin
                    res_idx_next    = '0;
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    res_idx_next    = free_idx;
                    res_status_next = ST_NEW;
                    if (op_reg == OP_ACQUIRE && held_ok_reg)
                    begin
                        upd_slot_next = held_reg;
                        upd_up_next   = 1'b0;
                        follow_next   = F_FILL;
                        state_next    = S_RMW_RD;
                    end
                    else
                    begin
                        state_next = S_FILL;
                    end
                end
            end

            S_RMW_RD:
            begin
                rd_addr    = upd_slot_reg;
                state_next = S_RMW_WR;
            end

            // count up or down with saturation, free at zero; permanent slots keep their count
            S_RMW_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = upd_slot_reg;
                wr_key   = rd_key;
                wr_dict  = rd_dict;
                wr_count = rd_count;
                wr_perm  = rd_perm;
                wr_comp  = rd_comp;
                if (!rd_perm)
                begin
                    if (upd_up_reg)
                    begin
                        if (rd_count != COUNT_MAX)
                        begin
                            wr_count = rd_count + COUNT_BITS'(1);
                        end
                    end
                    else if (rd_count != '0)
                    begin
                        wr_count = rd_count - COUNT_BITS'(1);
                        if (rd_count == COUNT_BITS'(1))
                        begin
                            wr_key  = '0;
                            wr_comp = 1'b0;
                        end
                    end
                end
                case (follow_reg)
                    F_UP:
                    begin
                        upd_slot_next = hit_idx;
                        upd_up_next   = 1'b1;
                        follow_next   = F_NONE;
                        state_next    = S_RMW_RD;
                    end
                    F_FILL:
                        state_next = S_FILL;
                    default:
                        state_next = S_DONE;
                endcase
            end

            // fill the free slot found by the scan
            S_FILL:
            begin
                wr_en   = 1'b1;
                wr_addr = free_idx;
                wr_key  = key_reg;
                wr_dict = dict_reg;
                if (op_reg == OP_ACQUIRE)
                begin
                    wr_count = COUNT_BITS'(1);
                    wr_perm  = 1'b0;
                    wr_comp  = comp_reg;
                end
                else
                begin
                    wr_count = '0;
                    wr_perm  = 1'b1;
                    wr_comp  = 1'b0;
                end
                state_next = S_DONE;
            end

            // read slot cnt, free slot cnt-1 unless permanent
            S_FLUSH:
            begin
                rd_addr  = cnt_reg[IW-1:0];
                wr_en    = (cnt_reg != '0) && !rd_perm;
                wr_addr  = prev_idx;
                wr_dict  = rd_dict;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(SLOTS))
                begin
                    state_next = S_DONE;
                end
            end

            // hand the result to the output register once it is free
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_idx_next    = 6'(res_idx_reg);
                    m_status_next = res_status_reg;
                    pend_next     = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            follow_reg   <= F_NONE;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
            follow_reg   <= follow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        dict_reg       <= dict_next;
        comp_reg       <= comp_next;
        held_ok_reg    <= held_ok_next;
        held_reg       <= held_next;
        upd_slot_reg   <= upd_slot_next;
        upd_up_reg     <= upd_up_next;
        res_idx_reg    <= res_idx_next;
        res_status_reg <= res_status_next;
        m_idx_reg      <= m_idx_next;
        m_status_reg   <= m_status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {2'b00, m_idx_reg};

    // no slot write while waiting for a transaction
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !wr_en)
        else $error("slot write while idle");

    // a fill only follows a scan that found a free slot
    a_fill_has_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FILL |-> sflags.have_free)
        else $error("fill without a free slot");

    // a full table reports slot zero
    a_full_zero_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_FULL |-> m_tdata == 8'd0)
        else $error("full status with nonzero slot");

    // leaving the done state loads the output and retires the item
    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && (!m_tvalid || m_tready) |=> m_tvalid && !pend_reg)
        else $error("result not loaded on completion");

endmodule

FILE: dv/slot_table_monitor.sv
`timescale 1ns / 1ps

module slot_table_monitor #(
    parameter int SLOTS      = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [2:0]  s_tuser,      // opcode
    input  logic [71:0] s_tdata,      // image_key, dictionary_handle, held_valid,
                                      // held_slot, is_compressed
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [1:0]  m_tuser,      // status
    input  logic [7:0]  m_tdata,      // slot_index, zero pad
    output int          mismatch_cnt,
    output int          pending_cnt
);

    import rist_pkg::*;

    localparam logic [COUNT_BITS-1:0] REF_MAX = '1;

    typedef struct {
        logic [5:0] slot_index;
        status_t    status;
    } slot_reply_t;

    // shadow copy of the slot table
    logic [31:0]           key_mem  [SLOTS];
    logic [31:0]           dict_mem [SLOTS];
    logic [COUNT_BITS-1:0] ref_cnt  [SLOTS];
    logic                  pin_mem  [SLOTS];
    logic                  comp_mem [SLOTS];

    slot_reply_t reply_q[$];
    slot_reply_t want;

    function automatic logic slot_free(int s);
        return !pin_mem[s] && (ref_cnt[s] == '0);
    endfunction

    function automatic void vacate_slot(int s);
        ref_cnt[s]  = '0;
        key_mem[s]  = '0;
        comp_mem[s] = 1'b0;
    endfunction

    function automatic void bump_ref(int s);
        if (!pin_mem[s] && ref_cnt[s] != REF_MAX)
            ref_cnt[s] = ref_cnt[s] + 1'b1;
    endfunction

    function automatic void drop_ref(int s);
        if (!pin_mem[s] && ref_cnt[s] != '0)
        begin
            ref_cnt[s] = ref_cnt[s] - 1'b1;
            if (ref_cnt[s] == '0)
                vacate_slot(s);
        end
    endfunction

    function automatic void wipe_table();
        for (int s = 0; s < SLOTS; s++)
        begin
            key_mem[s]  = '0;
            dict_mem[s] = '0;
            ref_cnt[s]  = '0;
            pin_mem[s]  = 1'b0;
            comp_mem[s] = 1'b0;
        end
    endfunction

    // applies one transaction to the shadow table and returns its reply
    function automatic slot_reply_t apply_slot_op(opcode_t op, logic [31:0] key,
                                                  logic [31:0] dict, logic hv,
                                                  logic [5:0] hs, logic comp);
        slot_reply_t r;
        int          hit;
        int          fre;
        logic        have_hit;
        logic        have_free;
        logic        held_ok;
        logic        match;
        r.slot_index = '0;
        r.status     = ST_DONE;
        hit          = 0;
        fre          = 0;
        have_hit     = 1'b0;
        have_free    = 1'b0;
        held_ok      = hv && (int'(hs) < SLOTS);
        case (op)
            OP_ACQUIRE, OP_PIN:
            begin
                // lowest matching slot and lowest free slot in one pass
                for (int s = 0; s < SLOTS; s++)
                begin
                    match = (key_mem[s] == key) &&
                            ((op == OP_ACQUIRE) ? !slot_free(s) : pin_mem[s]);
                    if (!have_free && slot_free(s))
                    begin
                        have_free = 1'b1;
                        fre       = s;
                    end
                    if (!have_hit && match)
                    begin
                        have_hit = 1'b1;
                        hit      = s;
                    end
                end
                if (have_hit)
                begin
                    if (op == OP_ACQUIRE && !(held_ok && int'(hs) == hit))
                    begin
                        if (held_ok)
                            drop_ref(int'(hs));
                        bump_ref(hit);
                    end
                    r.slot_index = 6'(hit);
                    r.status     = ST_HIT;
                end
                else if (!have_free)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // free slot was picked before the held slot goes away
                    if (op == OP_ACQUIRE && held_ok)
                        drop_ref(int'(hs));
                    key_mem[fre]  = key;
                    dict_mem[fre] = dict;
                    if (op == OP_ACQUIRE)
                    begin
                        ref_cnt[fre]  = COUNT_BITS'(1);
                        pin_mem[fre]  = 1'b0;
                        comp_mem[fre] = comp;
                    end
                    else
                    begin
                        ref_cnt[fre]  = '0;
                        pin_mem[fre]  = 1'b1;
                        comp_mem[fre] = 1'b0;
                    end
                    r.slot_index = 6'(fre);
                    r.status     = ST_NEW;
                end
            end
            OP_ADDREF:
            begin
                if (held_ok)
                    bump_ref(int'(hs));
            end
            OP_RELEASE:
            begin
                if (held_ok)
                    drop_ref(int'(hs));
            end
            OP_FLUSH:
            begin
                for (int s = 0; s < SLOTS; s++)
                    if (!pin_mem[s])
                        vacate_slot(s);
            end
            OP_CLEAR:
            begin
                wipe_table();
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // predict on each input transaction, compare on each output transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_table();
            reply_q.delete();
            mismatch_cnt = 0;
            pending_cnt  = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                reply_q.push_back(apply_slot_op(opcode_t'(s_tuser), s_tdata[31:0],
                                                s_tdata[63:32], s_tdata[64],
                                                s_tdata[70:65], s_tdata[71]));
            if (m_tvalid && m_tready)
            begin
                if (reply_q.size() == 0)
                begin
                    $error("unexpected result: slot_index %0d status %0d",
                           m_tdata[5:0], m_tuser);
                    mismatch_cnt++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (m_tdata[5:0] !== want.slot_index)
                    begin
                        $error("slot_index: expected %0d, actual %0d",
                               want.slot_index, m_tdata[5:0]);
                        mismatch_cnt++;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        mismatch_cnt++;
                    end
                end
            end
            pending_cnt = reply_q.size();
        end
    end

endmodule

FILE: dv/tb_refcounted_image_slot_table.sv
`timescale 1ns / 1ps

module tb_refcounted_image_slot_table;

    import rist_pkg::*;

    localparam int SLOTS        = 64;
    localparam int COUNT_BITS   = 16;
    localparam int RANDOM_ITEMS = 1350;
    localparam int HOLD_OFF     = 2000;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 200;
    // a long run of references on one slot, partly released afterwards
    localparam int SAT_ADDREFS  = 40;

    // opcodes the block answers without acting
    localparam opcode_t OP_SPARE_6 = 3'd6;
    localparam opcode_t OP_SPARE_7 = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [2:0]  s_tuser;    // opcode
    logic [71:0] s_tdata;    // image_key, dictionary_handle, held_valid,
                             // held_slot, is_compressed
    logic        m_tvalid;
    logic        m_tready;
    logic [1:0]  m_tuser;    // status
    logic [7:0]  m_tdata;    // slot_index, zero pad

    int   mismatch_cnt;
    int   pending_cnt;
    int   sent_cnt;
    int   burst_left;
    int   idle_cycles;
    logic rush;
    logic hold_armed;

    logic [31:0] key_pool [16];
    int          pool_size;

    refcounted_image_slot_table #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    slot_table_monitor #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tuser      (m_tuser),
        .m_tdata      (m_tdata),
        .mismatch_cnt (mismatch_cnt),
        .pending_cnt  (pending_cnt)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // sends one transaction, with a random gap at the start of each burst
    task automatic issue(input opcode_t op, input logic [31:0] key,
                         input logic [31:0] dict, input logic hv,
                         input logic [5:0] hs, input logic comp);
        int gap;
        gap = 0;
        if (!rush)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            burst_left--;
        end
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {comp, hs, hv, dict, key};
        do
            @(posedge clk);
        while (!s_tready);
        sent_cnt++;
    endtask

    // held slot: mostly among the low, busy slots, sometimes anywhere
    function automatic logic [5:0] pick_slot(int span);
        if ($urandom_range(0, 4) != 0)
            return 6'($urandom_range(0, span));
        return 6'($urandom_range(0, SLOTS - 1));
    endfunction

    // one of the all-zero, all-one or random keys
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // fills the table to around capacity (SLOTS - 4 to SLOTS + 8 acquires), then works at and near the full state
    task automatic fill_table();
        int n;
        n = $urandom_range(SLOTS - 4, SLOTS + 8);
        repeat (n)
            issue(OP_ACQUIRE, $urandom, $urandom, 1'($urandom_range(0, 5) == 0),
                  6'($urandom_range(0, SLOTS - 1)), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(2, 6))
        begin
            case ($urandom_range(0, 3))
                0: issue(OP_PIN, $urandom, $urandom, 1'b0, 6'd0, 1'b0);
                1: issue(OP_RELEASE, 32'h0, 32'h0, 1'b1, pick_slot(SLOTS - 1), 1'b0);
                default: issue(OP_ACQUIRE, $urandom, $urandom, 1'b1,
                               pick_slot(SLOTS - 1), 1'($urandom_range(0, 1)));
            endcase
        end
        case ($urandom_range(0, 3))
            0: issue(OP_FLUSH, $urandom, $urandom, 1'b0, 6'd0, 1'b0);
            1: issue(OP_CLEAR, $urandom, $urandom, 1'b0, 6'd0, 1'b0);
            default: ;
        endcase
    endtask

    // acquire/addref/release traffic on a small pool of keys, with pins, flushes, clears and spare opcodes
    task automatic churn_pool();
        int      len;
        int      r;
        opcode_t op;
        logic [31:0] key;
        pool_size = $urandom_range(1, 10);
        for (int i = 0; i < pool_size; i++)
            key_pool[i] = pick_key();
        len = $urandom_range(20, 60);
        repeat (len)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)      op = OP_ACQUIRE;
            else if (r < 60) op = OP_ADDREF;
            else if (r < 85) op = OP_RELEASE;
            else if (r < 91) op = OP_PIN;
            else if (r < 94) op = OP_FLUSH;
            else if (r < 96) op = OP_CLEAR;
            else if (r < 98) op = OP_SPARE_6;
            else             op = OP_SPARE_7;
            key = ($urandom_range(0, 9) == 0) ? $urandom
                                              : key_pool[$urandom_range(0, pool_size - 1)];
            issue(op, key, $urandom, 1'($urandom_range(0, 9) != 0),
                  pick_slot(pool_size + 3), 1'($urandom_range(0, 1)));
        end
    endtask

    // receiver: changing stall patterns, one long hold-off, none while rushing
    initial
    begin
        int mode;
        int left;
        logic held_off;
        m_tready = 1'b0;
        mode     = 0;
        left     = 0;
        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_armed && !held_off)
            begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF - 1)
                    @(negedge clk);
            end
            else if (rush)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 200);
                end
                left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ((left % 16) >= 12);
                endcase
            end
        end
    end

    // ends the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [31:0] sat_key;
        int          base_cnt;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = '0;
        s_tdata     = '0;
        rush        = 1'b0;
        hold_armed  = 1'b0;
        sent_cnt    = 0;
        burst_left  = 0;
        repeat (2)
            @(negedge clk);
        rst_n <= 1'b1;

        // key zero misses on the empty table
        issue(OP_ACQUIRE, 32'h0000_0000, 32'h0000_0000, 1'b0, 6'd0, 1'b0);
        // held slot is free, so nothing is released
        issue(OP_ACQUIRE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 6'd63, 1'b1);
        // hit on the slot the caller already holds
        issue(OP_ACQUIRE, 32'hFFFF_FFFF, 32'h0000_5A5A, 1'b1, 6'd1, 1'b0);
        // hit elsewhere frees the held slot
        issue(OP_ACQUIRE, 32'h0000_0000, 32'h0000_0000, 1'b1, 6'd1, 1'b0);
        issue(OP_ACQUIRE, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 6'd0, 1'b1);
        issue(OP_ADDREF, 32'h0, 32'h0, 1'b1, 6'd1, 1'b0);
        // not held
        issue(OP_ADDREF, 32'h0, 32'h0, 1'b0, 6'd1, 1'b0);
        // reference on a free slot makes it live with key zero
        issue(OP_ADDREF, 32'h0, 32'h0, 1'b1, 6'd63, 1'b0);
        issue(OP_ACQUIRE, 32'h0000_0000, 32'h0, 1'b0, 6'd0, 1'b0);
        issue(OP_RELEASE, 32'h0, 32'h0, 1'b1, 6'd63, 1'b0);
        // release of a free slot is ignored
        issue(OP_RELEASE, 32'h0, 32'h0, 1'b1, 6'd40, 1'b0);
        issue(OP_RELEASE, 32'h0, 32'h0, 1'b0, 6'd1, 1'b0);
        // permanent insert, then again for the same key
        issue(OP_PIN, 32'hCAFE_F00D, 32'h8000_0001, 1'b0, 6'd0, 1'b1);
        issue(OP_PIN, 32'hCAFE_F00D, 32'h1234_5678, 1'b0, 6'd0, 1'b0);
        // acquire of a pinned key: no count, held slot released
        issue(OP_ACQUIRE, 32'hCAFE_F00D, 32'h0, 1'b1, 6'd1, 1'b0);
        issue(OP_ADDREF, 32'h0, 32'h0, 1'b1, 6'd2, 1'b0);
        issue(OP_RELEASE, 32'h0, 32'h0, 1'b1, 6'd2, 1'b0);
        // pin a key that is live but not permanent
        issue(OP_PIN, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 6'd0, 1'b0);
        issue(OP_SPARE_6, 32'h0, 32'h0, 1'b0, 6'd0, 1'b0);
        issue(OP_SPARE_7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 6'd63, 1'b1);
        // flush keeps pinned slots
        issue(OP_FLUSH, 32'h0, 32'h0, 1'b0, 6'd0, 1'b0);
        issue(OP_ACQUIRE, 32'h0000_0000, 32'h0, 1'b0, 6'd0, 1'b0);
        issue(OP_CLEAR, 32'h0, 32'h0, 1'b0, 6'd0, 1'b0);
        issue(OP_ACQUIRE, 32'hCAFE_F00D, 32'h0, 1'b0, 6'd0, 1'b0);

        // references piling up on one slot, run without idling
        rush    = 1'b1;
        sat_key = $urandom;
        issue(OP_CLEAR, 32'h0, 32'h0, 1'b0, 6'd0, 1'b0);
        issue(OP_ACQUIRE, sat_key, $urandom, 1'b0, 6'd0, 1'b1);
        repeat (SAT_ADDREFS)
            issue(OP_ADDREF, 32'h0, 32'h0, 1'b1, 6'd0, 1'b0);
        issue(OP_ACQUIRE, sat_key, 32'h0, 1'b0, 6'd0, 1'b0);
        repeat (6)
            issue(OP_RELEASE, 32'h0, 32'h0, 1'b1, 6'd0, 1'b0);
        issue(OP_ACQUIRE, sat_key, 32'h0, 1'b0, 6'd0, 1'b0);
        issue(OP_CLEAR, 32'h0, 32'h0, 1'b0, 6'd0, 1'b0);
        rush = 1'b0;

        // random traffic: mostly pool churn, some table fills
        base_cnt = sent_cnt;
        while (sent_cnt - base_cnt < RANDOM_ITEMS)
        begin
            if (sent_cnt - base_cnt >= 300)
                hold_armed = 1'b1;
            if ($urandom_range(0, 3) == 0)
                fill_table();
            else
                churn_pool();
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending_cnt == 0);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
sv/rist_pkg.sv
sv/rist_store.sv
sv/rist_match.sv
sv/refcounted_image_slot_table.sv
dv/slot_table_monitor.sv
dv/tb_refcounted_image_slot_table.sv
